// ----- rtl/rti_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rti_pkg
// Shared widths and defaults for the ray / triangle intersection unit.
// ---------------------------------------------------------------------------
package rti_pkg;

  localparam int VEC_WIDTH       = 63;
  localparam int DIST_WIDTH      = 32;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_ADDR_WIDTH  = 1;
  localparam int COORD_WIDTH_DEF = 21;
  localparam int FRAC_SHIFT      = 16;

  localparam logic [CFG_ADDR_WIDTH-1:0] REG_MIN_DET = '0;
  localparam logic [CFG_DATA_WIDTH-1:0] MIN_DET_RST = 32'd1;

endpackage

// ----- rtl/rti_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rti_in_if
// Request channel: one ray and one triangle per item.
// ---------------------------------------------------------------------------
interface rti_in_if;
  import rti_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VEC_WIDTH-1:0] origin;
  logic [VEC_WIDTH-1:0] direction;
  logic [VEC_WIDTH-1:0] vertex_a;
  logic [VEC_WIDTH-1:0] vertex_b;
  logic [VEC_WIDTH-1:0] vertex_c;

  modport source (output valid, origin, direction, vertex_a, vertex_b, vertex_c,
                  input ready);
  modport sink (input valid, origin, direction, vertex_a, vertex_b, vertex_c,
                output ready);
endinterface

// ----- rtl/rti_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rti_out_if
// Result channel: hit flag and Q16.16 distance.
// ---------------------------------------------------------------------------
interface rti_out_if;
  import rti_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [DIST_WIDTH-1:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

// ----- rtl/ray_triangle_intersection_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_triangle_intersection_unit
// Fixed-point Moller-Trumbore ray / triangle test with back-face culling.
// ---------------------------------------------------------------------------
// Takes one request per cycle when the result channel does not stall and
// returns one result per request, in order: six arithmetic stages (edges,
// cross products, dot products, accept test) are followed by a 32-stage
// restoring divider that produces one quotient bit per stage, then the
// output register. The whole pipeline holds while the output register is
// full and not taken. min_determinant (address 0) is in units of 2^-30; its
// reset value 1 rejects any determinant <= 0.
module ray_triangle_intersection_unit #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  rti_in_if.sink                              in_req,
  rti_out_if.source                           out_res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rti_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [rti_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
  output logic [rti_pkg::CFG_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);
  import rti_pkg::*;

  localparam int CW = COORD_WIDTH + 1;   // edge / offset width
  localparam int PW = 2 * CW + 1;        // cross product width
  localparam int MW = CW + PW;           // dot term width
  localparam int DW = MW + 2;            // dot sum width
  localparam int RW = DW + DIST_WIDTH;   // divider remainder width
  localparam int NS = DIST_WIDTH;        // divider stages

  // ---------------- configuration ----------------
  logic [CFG_DATA_WIDTH-1:0] min_det_r;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MIN_DET) ? min_det_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_det_r <= MIN_DET_RST;
    end else if (psel && penable && pwrite && paddr == REG_MIN_DET) begin
      min_det_r <= pwdata;
    end
  end

  // ---------------- flow control ----------------
  logic en;
  logic out_valid_r;
  assign en           = !out_valid_r || out_res.ready;
  assign in_req.ready = en;

  // ---------------- stage 1: unpack, edges ----------------
  logic signed [COORD_WIDTH-1:0] o_c [3];
  logic signed [COORD_WIDTH-1:0] d_c [3];
  logic signed [COORD_WIDTH-1:0] a_c [3];
  logic signed [COORD_WIDTH-1:0] b_c [3];
  logic signed [COORD_WIDTH-1:0] c_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      o_c[k] = in_req.origin[k*COORD_WIDTH +: COORD_WIDTH];
      d_c[k] = in_req.direction[k*COORD_WIDTH +: COORD_WIDTH];
      a_c[k] = in_req.vertex_a[k*COORD_WIDTH +: COORD_WIDTH];
      b_c[k] = in_req.vertex_b[k*COORD_WIDTH +: COORD_WIDTH];
      c_c[k] = in_req.vertex_c[k*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  logic              v1_r;
  logic signed [CW-1:0] d1_r [3];
  logic signed [CW-1:0] e1_1_r [3];
  logic signed [CW-1:0] e2_1_r [3];
  logic signed [CW-1:0] s1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k]   <= CW'(d_c[k]);
        e1_1_r[k] <= CW'(b_c[k]) - CW'(a_c[k]);
        e2_1_r[k] <= CW'(c_c[k]) - CW'(a_c[k]);
        s1_r[k]   <= CW'(o_c[k]) - CW'(a_c[k]);
      end
    end
  end

  // ---------------- stage 2: cross product terms ----------------
  // p = d x e2, q = s x e1; index j of axis pair (j+1, j+2)
  logic                   v2_r;
  logic signed [2*CW-1:0] pl_r [3];
  logic signed [2*CW-1:0] pr_r [3];
  logic signed [2*CW-1:0] ql_r [3];
  logic signed [2*CW-1:0] qr_r [3];
  logic signed [CW-1:0]   d2_r [3];
  logic signed [CW-1:0]   e1_2_r [3];
  logic signed [CW-1:0]   e2_2_r [3];
  logic signed [CW-1:0]   s2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pl_r[k]   <= d1_r[(k+1)%3] * e2_1_r[(k+2)%3];
        pr_r[k]   <= d1_r[(k+2)%3] * e2_1_r[(k+1)%3];
        ql_r[k]   <= s1_r[(k+1)%3] * e1_1_r[(k+2)%3];
        qr_r[k]   <= s1_r[(k+2)%3] * e1_1_r[(k+1)%3];
        d2_r[k]   <= d1_r[k];
        e1_2_r[k] <= e1_1_r[k];
        e2_2_r[k] <= e2_1_r[k];
        s2_r[k]   <= s1_r[k];
      end
    end
  end

  // ---------------- stage 3: cross products ----------------
  logic                 v3_r;
  logic signed [PW-1:0] p3_r [3];
  logic signed [PW-1:0] q3_r [3];
  logic signed [CW-1:0] d3_r [3];
  logic signed [CW-1:0] e1_3_r [3];
  logic signed [CW-1:0] e2_3_r [3];
  logic signed [CW-1:0] s3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p3_r[k]   <= PW'(pl_r[k]) - PW'(pr_r[k]);
        q3_r[k]   <= PW'(ql_r[k]) - PW'(qr_r[k]);
        d3_r[k]   <= d2_r[k];
        e1_3_r[k] <= e1_2_r[k];
        e2_3_r[k] <= e2_2_r[k];
        s3_r[k]   <= s2_r[k];
      end
    end
  end

  // ---------------- stage 4: dot product terms ----------------
  logic                 v4_r;
  logic signed [MW-1:0] det_m_r [3];
  logic signed [MW-1:0] u_m_r [3];
  logic signed [MW-1:0] v_m_r [3];
  logic signed [MW-1:0] t_m_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        det_m_r[k] <= e1_3_r[k] * p3_r[k];
        u_m_r[k]   <= s3_r[k] * p3_r[k];
        v_m_r[k]   <= d3_r[k] * q3_r[k];
        t_m_r[k]   <= e2_3_r[k] * q3_r[k];
      end
    end
  end

  // ---------------- stage 5: dot sums ----------------
  logic                 v5_r;
  logic signed [DW-1:0] det5_r, u5_r, vn5_r, t5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det5_r <= DW'(det_m_r[0]) + DW'(det_m_r[1]) + DW'(det_m_r[2]);
      u5_r   <= DW'(u_m_r[0]) + DW'(u_m_r[1]) + DW'(u_m_r[2]);
      vn5_r  <= DW'(v_m_r[0]) + DW'(v_m_r[1]) + DW'(v_m_r[2]);
      t5_r   <= DW'(t_m_r[0]) + DW'(t_m_r[1]) + DW'(t_m_r[2]);
    end
  end

  // ---------------- stage 6: accept test, saturation ----------------
  logic signed [DW:0]   uv_sum;
  logic signed [DW-1:0] min_det_s;
  logic                 hit_c, sat_c;
  logic [RW-1:0]        det_sh16, t_sh16;

  always_comb begin
    uv_sum    = (DW+1)'(u5_r) + (DW+1)'(vn5_r);
    min_det_s = DW'({1'b0, min_det_r});
    hit_c     = !det5_r[DW-1] && (det5_r != '0) && (det5_r >= min_det_s) &&
                !u5_r[DW-1] && (u5_r <= det5_r) &&
                !vn5_r[DW-1] && (uv_sum <= (DW+1)'(det5_r)) &&
                !t5_r[DW-1];
    det_sh16  = RW'(det5_r) << FRAC_SHIFT;
    t_sh16    = RW'(t5_r) << FRAC_SHIFT;
    sat_c     = RW'(t5_r) >= det_sh16;
  end

  // divider pipeline: index 0 is the entry register
  logic                  dv_r   [NS+1];
  logic                  dhit_r [NS+1];
  logic                  dsat_r [NS+1];
  logic [DW-1:0]         ddet_r [NS+1];
  logic [RW-1:0]         drem_r [NS+1];
  logic [DIST_WIDTH-1:0] dquo_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dhit_r[0] <= hit_c;
      dsat_r[0] <= sat_c;
      ddet_r[0] <= det5_r;
      drem_r[0] <= t_sh16;
      dquo_r[0] <= '0;
    end
  end

  // ---------------- stages 7..38: restoring division ----------------
  for (genvar i = 0; i < NS; i++) begin : g_div
    localparam int SH = NS - 1 - i;
    logic [RW-1:0] dsh;
    logic          ge;

    assign dsh = RW'(ddet_r[i]) << SH;
    assign ge  = drem_r[i] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1] <= 1'b0;
      end else if (en) begin
        dv_r[i+1] <= dv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dhit_r[i+1] <= dhit_r[i];
        dsat_r[i+1] <= dsat_r[i];
        ddet_r[i+1] <= ddet_r[i];
        drem_r[i+1] <= ge ? drem_r[i] - dsh : drem_r[i];
        dquo_r[i+1] <= dquo_r[i] | (ge ? (DIST_WIDTH'(1) << SH) : '0);
      end
    end
  end

  // ---------------- output register ----------------
  logic                  hit_r;
  logic [DIST_WIDTH-1:0] dist_r;
  logic [DIST_WIDTH-1:0] dist_nxt;

  always_comb begin
    if (!dhit_r[NS]) begin
      dist_nxt = '0;
    end else if (dsat_r[NS]) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = dquo_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= dhit_r[NS];
      dist_r <= dist_nxt;
    end
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.hit      = hit_r;
  assign out_res.distance = dist_r;

endmodule
